// File: rtl/mcsf_pkg.sv
`default_nettype none

package mcsf_pkg;

   localparam int RAW_W      = 12;
   localparam int OFFSET_W   = 12;
   localparam int CUR_W      = 16;
   localparam int SUM_W      = 22;
   localparam int CAL_CNT_W  = 10;
   localparam int DEC_CNT_W  = 6;
   localparam int RATIO_W    = 7;
   localparam int LIMIT_W    = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 15'd5000;
   localparam logic [RATIO_W-1:0]   RATIO_RESET = 7'd8;
   localparam logic [RATIO_W-1:0]   RATIO_MIN   = 7'd1;
   localparam logic [RATIO_W-1:0]   RATIO_MAX   = 7'd64;
   localparam logic [CAL_CNT_W-1:0] CAL_CNT_RESET = 10'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_OC_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIM    = 2'd1;

   typedef enum logic {
      CMD_FILTER    = 1'b0,
      CMD_CALIBRATE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic filter_en;
      logic accum_en;
      logic finish;
   } phase_ctl_type;

   typedef struct packed {
      logic signed [CUR_W-1:0] current_a;
      logic signed [CUR_W-1:0] current_b;
      logic                    current_valid;
      logic                    over_current;
      logic                    offset_ready;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/motor_current_sense_frontend_core.sv
// Two-phase motor current front end.
// req_* carries one beat per converter event: cmd selects a filter update
// (leaky integrator per phase, offset removed, saturated to 16 bits) or a
// calibration tick (over-current check on the published currents, then
// offset averaging over CAL_SAMPLES idle samples).
// rsp_* returns exactly one beat per request beat: the published currents,
// the publish flag, the over-current flag and the offset-ready flag.
// csr_* writes the over-current limit (index 0) and the decimation ratio
// (index 1); csr_ready is always high. Write only while no beat is in flight.
// Results are registered in the output buffer before rsp_* offers them.
// Throughput: one beat per cycle unless the buffer is full; each beat is
// settled in the cycle it is accepted; the offset divide is a multiply
// by a constant reciprocal. A two-entry output buffer holds results while
// the receiver stalls; req_ready drops only when both entries are occupied.
// Reset (synchronous, active high) clears filters, sums, offsets and the
// output buffer, sets the calibration count to one and loads the register
// defaults (limit 5000, ratio 8). No clearing pass follows reset.
`default_nettype none

module motor_current_sense_frontend_core #(
   parameter int LEAK_SHIFT   = 3,
   parameter int CAL_SAMPLES  = 100
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_cmd,
   input  wire logic [mcsf_pkg::RAW_W-1:0]            req_ia_raw,
   input  wire logic [mcsf_pkg::RAW_W-1:0]            req_ib_raw,
   input  wire logic                                  req_motor_idle,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [mcsf_pkg::CUR_W-1:0]          rsp_current_a,
   output logic signed [mcsf_pkg::CUR_W-1:0]          rsp_current_b,
   output logic                                       rsp_current_valid,
   output logic                                       rsp_over_current,
   output logic                                       rsp_offset_ready,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mcsf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [mcsf_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic [mcsf_pkg::LIMIT_W-1:0]       limit_ff;
   logic [mcsf_pkg::RATIO_W-1:0]       ratio_ff;
   logic [mcsf_pkg::RATIO_W-1:0]       ratio_eff;
   logic [mcsf_pkg::DEC_CNT_W-1:0]     dec_cnt_ff;
   logic [mcsf_pkg::RATIO_W-1:0]       dec_next;
   logic [mcsf_pkg::CAL_CNT_W-1:0]     cal_cnt_ff;
   logic                               calibrated_ff;
   logic                               calibrated_in;
   logic signed [mcsf_pkg::CUR_W-1:0]  pub_a_ff;
   logic signed [mcsf_pkg::CUR_W-1:0]  pub_b_ff;
   logic signed [mcsf_pkg::CUR_W-1:0]  pub_a_in;
   logic signed [mcsf_pkg::CUR_W-1:0]  pub_b_in;
   logic signed [mcsf_pkg::CUR_W-1:0]  filt_a;
   logic signed [mcsf_pkg::CUR_W-1:0]  filt_b;
   logic [mcsf_pkg::CUR_W-1:0]         mag_a;
   logic [mcsf_pkg::CUR_W-1:0]         mag_b;
   logic                               accept;
   logic                               is_filter;
   logic                               is_cal;
   logic                               dec_hit;
   logic                               publish;
   logic                               over_cur;
   logic                               buf_full;
   mcsf_pkg::phase_ctl_type            ctl;
   mcsf_pkg::rsp_type                  rsp_in;
   mcsf_pkg::rsp_type                  rsp_out;

   assign accept    = req_valid && req_ready;
   assign is_filter = (mcsf_pkg::cmd_type'(req_cmd) == mcsf_pkg::CMD_FILTER);
   assign is_cal    = (mcsf_pkg::cmd_type'(req_cmd) == mcsf_pkg::CMD_CALIBRATE);
   assign csr_ready = 1'b1;

   always_comb begin
      if (ratio_ff < mcsf_pkg::RATIO_MIN) begin
         ratio_eff = mcsf_pkg::RATIO_MIN;
      end else if (ratio_ff > mcsf_pkg::RATIO_MAX) begin
         ratio_eff = mcsf_pkg::RATIO_MAX;
      end else begin
         ratio_eff = ratio_ff;
      end
   end

   assign dec_next = mcsf_pkg::RATIO_W'(dec_cnt_ff) + mcsf_pkg::RATIO_W'(1);
   assign dec_hit  = (dec_next >= ratio_eff);
   assign publish  = is_filter && dec_hit;

   assign ctl.filter_en = accept && is_filter;
   assign ctl.accum_en  = accept && is_cal && req_motor_idle;
   assign ctl.finish    = (cal_cnt_ff >= mcsf_pkg::CAL_CNT_W'(CAL_SAMPLES));

   mcsf_phase #(
      .LEAK_SHIFT   (LEAK_SHIFT),
      .CAL_SAMPLES  (CAL_SAMPLES)
   ) u_phase_a (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .raw        (req_ia_raw),
      .filter_upd (filt_a)
   );

   mcsf_phase #(
      .LEAK_SHIFT   (LEAK_SHIFT),
      .CAL_SAMPLES  (CAL_SAMPLES)
   ) u_phase_b (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .raw        (req_ib_raw),
      .filter_upd (filt_b)
   );

   assign pub_a_in = publish ? filt_a : pub_a_ff;
   assign pub_b_in = publish ? filt_b : pub_b_ff;

   assign mag_a = pub_a_ff[mcsf_pkg::CUR_W-1] ? -pub_a_ff : pub_a_ff;
   assign mag_b = pub_b_ff[mcsf_pkg::CUR_W-1] ? -pub_b_ff : pub_b_ff;
   assign over_cur = is_cal && calibrated_ff &&
                     ((mag_a > mcsf_pkg::CUR_W'(limit_ff)) ||
                      (mag_b > mcsf_pkg::CUR_W'(limit_ff)));

   assign calibrated_in = calibrated_ff || (ctl.accum_en && ctl.finish);

   assign rsp_in.current_a     = pub_a_in;
   assign rsp_in.current_b     = pub_b_in;
   assign rsp_in.current_valid = publish;
   assign rsp_in.over_current  = over_cur;
   assign rsp_in.offset_ready  = calibrated_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= mcsf_pkg::LIMIT_RESET;
         ratio_ff      <= mcsf_pkg::RATIO_RESET;
         dec_cnt_ff    <= '0;
         cal_cnt_ff    <= mcsf_pkg::CAL_CNT_RESET;
         calibrated_ff <= 1'b0;
         pub_a_ff      <= '0;
         pub_b_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mcsf_pkg::CSR_OC_LIMIT: limit_ff <= csr_data[mcsf_pkg::LIMIT_W-1:0];
               mcsf_pkg::CSR_DECIM:    ratio_ff <= csr_data[mcsf_pkg::RATIO_W-1:0];
               default: ;
            endcase
         end
         if (ctl.filter_en) begin
            pub_a_ff <= pub_a_in;
            pub_b_ff <= pub_b_in;
            if (dec_hit) begin
               dec_cnt_ff <= '0;
            end else begin
               dec_cnt_ff <= dec_next[mcsf_pkg::DEC_CNT_W-1:0];
            end
         end
         if (ctl.accum_en) begin
            if (ctl.finish) begin
               cal_cnt_ff <= mcsf_pkg::CAL_CNT_RESET;
            end else begin
               cal_cnt_ff <= cal_cnt_ff + mcsf_pkg::CAL_CNT_W'(1);
            end
         end
         calibrated_ff <= calibrated_in && !reset;
      end
   end

   mcsf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_in),
      .full      (buf_full),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_out)
   );

   assign req_ready         = !buf_full;
   assign rsp_current_a     = rsp_out.current_a;
   assign rsp_current_b     = rsp_out.current_b;
   assign rsp_current_valid = rsp_out.current_valid;
   assign rsp_over_current  = rsp_out.over_current;
   assign rsp_offset_ready  = rsp_out.offset_ready;

endmodule

`default_nettype wire

// File: rtl/mcsf_phase.sv
`default_nettype none

module mcsf_phase #(
   parameter int LEAK_SHIFT   = 3,
   parameter int CAL_SAMPLES  = 100
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mcsf_pkg::phase_ctl_type             ctl,
   input  wire logic [mcsf_pkg::RAW_W-1:0]          raw,
   output logic signed [mcsf_pkg::CUR_W-1:0]        filter_upd
);

   localparam int EXT_W       = mcsf_pkg::CUR_W + 2;
   localparam int CAL_LOG     = $clog2(CAL_SAMPLES);
   localparam int RECIP_SHIFT = mcsf_pkg::SUM_W + CAL_LOG;
   localparam int RECIP_W     = mcsf_pkg::SUM_W + 1;
   localparam int PROD_W      = mcsf_pkg::SUM_W + RECIP_W;
   localparam logic [63:0] RECIP =
      ((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(32767);
   localparam logic signed [EXT_W-1:0] SAT_LO = -EXT_W'(32768);

   logic signed [mcsf_pkg::CUR_W-1:0]  filter_ff;
   logic [mcsf_pkg::SUM_W-1:0]         sum_ff;
   logic [mcsf_pkg::SUM_W-1:0]         sum_in;
   logic [mcsf_pkg::OFFSET_W-1:0]      offset_ff;
   logic signed [mcsf_pkg::RAW_W:0]    sample;
   logic signed [EXT_W-1:0]            leak_sum;
   logic [PROD_W-1:0]                  product;
   logic [mcsf_pkg::OFFSET_W-1:0]      offset_in;

   assign sample = $signed({1'b0, raw}) - $signed({1'b0, offset_ff});
   assign leak_sum = EXT_W'(filter_ff) - EXT_W'(filter_ff >>> LEAK_SHIFT)
                     + EXT_W'(sample);

   always_comb begin
      if (leak_sum > SAT_HI) begin
         filter_upd = SAT_HI[mcsf_pkg::CUR_W-1:0];
      end else if (leak_sum < SAT_LO) begin
         filter_upd = SAT_LO[mcsf_pkg::CUR_W-1:0];
      end else begin
         filter_upd = leak_sum[mcsf_pkg::CUR_W-1:0];
      end
   end

   assign sum_in    = sum_ff + mcsf_pkg::SUM_W'(raw);
   assign product   = PROD_W'(sum_in) * PROD_W'(RECIP[RECIP_W-1:0]);
   assign offset_in = product[RECIP_SHIFT +: mcsf_pkg::OFFSET_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= '0;
         sum_ff    <= '0;
         offset_ff <= '0;
      end else begin
         if (ctl.filter_en) begin
            filter_ff <= filter_upd;
         end
         if (ctl.accum_en) begin
            if (ctl.finish) begin
               sum_ff    <= '0;
               offset_ff <= offset_in;
            end else begin
               sum_ff <= sum_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/mcsf_out_buf.sv
`default_nettype none

module mcsf_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mcsf_pkg::rsp_type push_data,
   output logic                   full,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output mcsf_pkg::rsp_type      pop_data
);

   mcsf_pkg::rsp_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/mcsf_checker.sv
`default_nettype none

module mcsf_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_ready,
   input wire logic                                  req_cmd,
   input wire logic [mcsf_pkg::RAW_W-1:0]            req_ia_raw,
   input wire logic [mcsf_pkg::RAW_W-1:0]            req_ib_raw,
   input wire logic                                  req_motor_idle,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic signed [mcsf_pkg::CUR_W-1:0]     rsp_current_a,
   input wire logic signed [mcsf_pkg::CUR_W-1:0]     rsp_current_b,
   input wire logic                                  rsp_current_valid,
   input wire logic                                  rsp_over_current,
   input wire logic                                  rsp_offset_ready,
   input wire logic                                  csr_valid,
   input wire logic                                  csr_ready,
   input wire logic [mcsf_pkg::CSR_IDX_W-1:0]        csr_index,
   input wire logic [mcsf_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_ready, req_cmd, req_ia_raw, req_ib_raw,
                        req_motor_idle, csr_valid, csr_ready, csr_index, csr_data};

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_current_valid && rsp_over_current))
      else $error("publish and over-current flagged on one beat");

   a_oc_needs_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_over_current) |-> rsp_offset_ready)
      else $error("over-current flagged before offset calibration");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_current_a) && $stable(rsp_current_b)))
      else $error("stalled result beat changed");

endmodule

bind motor_current_sense_frontend_core mcsf_checker u_mcsf_checker (.*);

`default_nettype wire
